// ===== hdl/eagts_pkg.sv =====
// shared types and constants for the edge angle gated template score core
// no dependencies; imported by every module of the block
package eagts_pkg;

  // field widths
  localparam int WEIGHT_W   = 4;
  localparam int STRENGTH_W = 8;
  localparam int BRIGHT_W   = 8;
  localparam int ANGLE_W    = 16;
  localparam int REF_W      = 15;
  localparam int LIMIT_W    = 15;
  localparam int SCORE_W    = 22;
  localparam int PROD_W     = STRENGTH_W + 1 + WEIGHT_W;
  localparam int FOLD_W     = ANGLE_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // binary angle units, pi = 16384
  localparam logic signed [FOLD_W-1:0] HALF_PI = FOLD_W'(8192);
  localparam logic signed [FOLD_W-1:0] PI      = FOLD_W'(16384);

  // saturation bounds of the score
  localparam logic signed [SCORE_W:0] SCORE_MAX = (SCORE_W+1)'(2097151);
  localparam logic signed [SCORE_W:0] SCORE_MIN = -(SCORE_W+1)'(2097152);

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_REF_ANGLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_LIMIT  = 2'd2;
  localparam logic [BRIGHT_W-1:0]  DARK_LIMIT_RST  = 8'd120;

  // configuration register set
  typedef struct packed {
    logic signed [REF_W-1:0] reference_angle;
    logic [LIMIT_W-1:0]      angle_limit;
    logic [BRIGHT_W-1:0]     dark_limit;
  } cfg_t;

  // one registered pixel
  typedef struct packed {
    logic signed [WEIGHT_W-1:0] template_weight;
    logic [STRENGTH_W-1:0]      edge_strength;
    logic [BRIGHT_W-1:0]        brightness;
    logic signed [ANGLE_W-1:0]  edge_angle;
    logic                       last_pixel;
  } pixel_t;

  // step handed to the accumulator
  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic signed [PROD_W-1:0] contrib;
  } step_t;

endpackage

// ===== hdl/edge_angle_gated_template_score_core.sv =====
// top level of the edge angle gated template score core
// depends on eagts_pkg, eagts_gate and eagts_accum
//
// Scores an image window against an oriented edge template, one pixel per
// transfer, at a sustained rate of one pixel per clock. A pixel is captured in
// an input register; the next cycle its gated, angle-checked weighted strength
// is added with saturation to the running score. On the pixel flagged last the
// score is loaded into the result register and the running score restarts at
// zero. Pixels keep flowing while a result waits; input stalls only when a
// second window end reaches the accumulator before the previous score has
// been taken. Configuration writes are accepted in every cycle and should be
// made between windows.
module edge_angle_gated_template_score_core (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // pixel input
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic signed [eagts_pkg::WEIGHT_W-1:0]       in_template_weight,
  input  logic [eagts_pkg::STRENGTH_W-1:0]            in_edge_strength,
  input  logic [eagts_pkg::BRIGHT_W-1:0]              in_brightness,
  input  logic signed [eagts_pkg::ANGLE_W-1:0]        in_edge_angle,
  input  logic                                        in_last_pixel,
  // score output
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic signed [eagts_pkg::SCORE_W-1:0]        out_score,
  // configuration writes
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [eagts_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [eagts_pkg::CFG_DATA_W-1:0]            cfg_data
);
  import eagts_pkg::*;

  cfg_t                     cfg_r, cfg_nxt;
  pixel_t                   pix_r, pix_nxt;
  logic                     s1_valid_r, s1_valid_nxt;
  logic                     in_accept;
  logic                     acc_ready;
  logic                     s1_take;
  logic signed [PROD_W-1:0] contrib;
  step_t                    step;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REF_ANGLE:   cfg_nxt.reference_angle = $signed(cfg_data[REF_W-1:0]);
        CFG_ANGLE_LIMIT: cfg_nxt.angle_limit     = cfg_data[LIMIT_W-1:0];
        CFG_DARK_LIMIT:  cfg_nxt.dark_limit      = cfg_data[BRIGHT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reference_angle <= '0;
      cfg_r.angle_limit     <= '0;
      cfg_r.dark_limit      <= DARK_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input register handshake; a last pixel waits for a free result register
  assign s1_take   = s1_valid_r && (!pix_r.last_pixel || acc_ready);
  assign in_stall  = s1_valid_r && !s1_take;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r && !s1_take;
    pix_nxt      = pix_r;
    if (in_accept) begin
      s1_valid_nxt             = 1'b1;
      pix_nxt.template_weight  = in_template_weight;
      pix_nxt.edge_strength    = in_edge_strength;
      pix_nxt.brightness       = in_brightness;
      pix_nxt.edge_angle       = in_edge_angle;
      pix_nxt.last_pixel       = in_last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  // pixel gating and weighting
  eagts_gate u_gate (
    .pix     (pix_r),
    .cfg     (cfg_r),
    .contrib (contrib)
  );

  assign step.valid   = s1_take;
  assign step.last    = pix_r.last_pixel;
  assign step.contrib = contrib;

  // running score and result register
  eagts_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .step_ready (acc_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_score  (out_score)
  );

  // a new score appears only after a last pixel left the input register
  a_score_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid_r && pix_r.last_pixel))
    else $error("score appeared without a last pixel");

  // input stalls only behind a window end blocked by a waiting score
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && pix_r.last_pixel && out_valid && out_stall))
    else $error("input stalled without a blocked window end");

  // a taken score is not shown again unless a new window ended
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !(s1_valid_r && pix_r.last_pixel)) |=> !out_valid)
    else $error("score repeated after transfer");

endmodule

// ===== hdl/eagts_gate.sv =====
// pixel gating: dark/weight/strength test, angle fold and compare, weighted strength
// depends on eagts_pkg
module eagts_gate (
  input  eagts_pkg::pixel_t                      pix,
  input  eagts_pkg::cfg_t                        cfg,
  output logic signed [eagts_pkg::PROD_W-1:0]    contrib
);
  import eagts_pkg::*;

  logic                     pass_gate;
  logic signed [FOLD_W-1:0] edge_ext;
  logic signed [FOLD_W-1:0] folded;
  logic signed [FOLD_W:0]   diff;
  logic [FOLD_W:0]          diff_abs;
  logic                     pass_angle;
  logic signed [PROD_W-1:0] product;

  // pixel must have weight, strength and be dark enough
  assign pass_gate = (pix.template_weight != '0) && (pix.edge_strength != '0) &&
                     (pix.brightness < cfg.dark_limit);

  // single fold toward (-pi/2, pi/2]
  assign edge_ext = FOLD_W'(pix.edge_angle);
  always_comb begin
    if (edge_ext <= -HALF_PI) begin
      folded = edge_ext + PI;
    end else if (edge_ext > HALF_PI) begin
      folded = edge_ext - PI;
    end else begin
      folded = edge_ext;
    end
  end

  // absolute difference against the reference
  assign diff       = (FOLD_W+1)'(cfg.reference_angle) - (FOLD_W+1)'(folded);
  assign diff_abs   = diff[FOLD_W] ? (FOLD_W+1)'(-diff) : (FOLD_W+1)'(diff);
  assign pass_angle = diff_abs < (FOLD_W+1)'(cfg.angle_limit);

  // weighted strength
  assign product = $signed({1'b0, pix.edge_strength}) * PROD_W'(pix.template_weight);
  assign contrib = (pass_gate && pass_angle) ? product : '0;

endmodule

// ===== hdl/eagts_accum.sv =====
// saturating running score and result register
// depends on eagts_pkg
module eagts_accum (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  eagts_pkg::step_t                      step,
  output logic                                  step_ready,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [eagts_pkg::SCORE_W-1:0]  out_score
);
  import eagts_pkg::*;

  logic signed [SCORE_W-1:0] run_r, run_nxt;
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SCORE_W:0]   sum;
  logic signed [SCORE_W-1:0] sat;

  // result register can take a new window score
  assign step_ready = !out_valid_r || !out_stall;

  // add and clamp
  assign sum = (SCORE_W+1)'(run_r) + (SCORE_W+1)'(step.contrib);
  always_comb begin
    if (sum > SCORE_MAX) begin
      sat = SCORE_MAX[SCORE_W-1:0];
    end else if (sum < SCORE_MIN) begin
      sat = SCORE_MIN[SCORE_W-1:0];
    end else begin
      sat = sum[SCORE_W-1:0];
    end
  end

  // next state
  always_comb begin
    run_nxt       = run_r;
    score_nxt     = score_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (step.valid) begin
      if (step.last) begin
        run_nxt       = '0;
        score_nxt     = sat;
        out_valid_nxt = 1'b1;
      end else begin
        run_nxt = sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_score = score_r;

endmodule

// ===== tb/edge_angle_gated_template_score_core_tb.sv =====
// self-checking testbench for edge_angle_gated_template_score_core
// depends on eagts_pkg and the core; drives pixels and config writes, checks scores
`timescale 1ns / 1ps

module edge_angle_gated_template_score_core_tb;
  import eagts_pkg::*;

  localparam int HALF_PI_BAU     = 8192;
  localparam int PI_BAU          = 16384;
  localparam int SCORE_TOP       = 2097151;
  localparam int SCORE_BOTTOM    = -2097152;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int RANDOM_PHASES   = 7;
  localparam int PHASE_PIXELS    = 80;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE, STALL_HOLD} stall_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid           = 1'b0;
  logic                        in_stall;
  logic signed [WEIGHT_W-1:0]  in_template_weight = '0;
  logic [STRENGTH_W-1:0]       in_edge_strength   = '0;
  logic [BRIGHT_W-1:0]         in_brightness      = '0;
  logic signed [ANGLE_W-1:0]   in_edge_angle      = '0;
  logic                        in_last_pixel      = 1'b0;
  logic                        out_valid;
  logic                        out_stall          = 1'b0;
  logic signed [SCORE_W-1:0]   out_score;
  logic                        cfg_valid          = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index          = '0;
  logic [CFG_DATA_W-1:0]       cfg_data           = '0;

  // pixels waiting to be driven, and scores expected from the core
  pixel_t                    pixel_q[$];
  logic signed [SCORE_W-1:0] window_score_q[$];

  // predictor copy of the config registers and the accumulator
  logic signed [REF_W-1:0] ref_angle_cfg   = '0;
  logic [LIMIT_W-1:0]      angle_limit_cfg = '0;
  logic [BRIGHT_W-1:0]     dark_limit_cfg  = DARK_LIMIT_RST;
  int                      window_sum      = 0;

  logic        in_fire      = 1'b0;
  int          burst_left   = 0;
  int          idle_left    = 0;
  int          stall_tick   = 0;
  stall_mode_t stall_mode   = STALL_NONE;
  int          quiet_cycles = 0;
  int          errors       = 0;

  edge_angle_gated_template_score_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_template_weight (in_template_weight),
    .in_edge_strength   (in_edge_strength),
    .in_brightness      (in_brightness),
    .in_edge_angle      (in_edge_angle),
    .in_last_pixel      (in_last_pixel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_score          (out_score),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #4 clk = ~clk;

  // predict the effect of one accepted pixel on the window score
  task automatic score_pixel(input pixel_t px);
    int folded;
    int diff;
    int sum;
    folded = px.edge_angle;
    // single fold toward (-pi/2, pi/2]
    if (folded <= -HALF_PI_BAU) begin
      folded += PI_BAU;
    end else if (folded > HALF_PI_BAU) begin
      folded -= PI_BAU;
    end
    diff = int'(ref_angle_cfg) - folded;
    if (diff < 0) begin
      diff = -diff;
    end
    if (px.template_weight != 0 && px.edge_strength != 0 &&
        px.brightness < dark_limit_cfg && diff < int'(angle_limit_cfg)) begin
      sum = window_sum + int'(px.edge_strength) * int'(px.template_weight);
      if (sum > SCORE_TOP) begin
        sum = SCORE_TOP;
      end
      if (sum < SCORE_BOTTOM) begin
        sum = SCORE_BOTTOM;
      end
      window_sum = sum;
    end
    // last pixel closes the window
    if (px.last_pixel) begin
      window_score_q.push_back(SCORE_W'(window_sum));
      window_sum = 0;
    end
  endtask

  function automatic pixel_t make_pixel(int w, int s, int b, int a, bit last);
    pixel_t px;
    px.template_weight = WEIGHT_W'(w);
    px.edge_strength   = STRENGTH_W'(s);
    px.brightness      = BRIGHT_W'(b);
    px.edge_angle      = ANGLE_W'(a);
    px.last_pixel      = last;
    return px;
  endfunction

  // random pixel biased toward counting pixels, near-reference angles and fold edges
  function automatic pixel_t rand_pixel(int ref_ang, int lim, int dark, bit last);
    pixel_t px;
    int     span;
    int     ang;
    px.template_weight = WEIGHT_W'($urandom);
    case ($urandom_range(0, 9))
      0:       px.edge_strength = '0;
      1:       px.edge_strength = '1;
      default: px.edge_strength = STRENGTH_W'($urandom);
    endcase
    if (dark > 0 && $urandom_range(0, 9) < 7) begin
      px.brightness = BRIGHT_W'($urandom_range(0, dark - 1));
    end else begin
      px.brightness = BRIGHT_W'($urandom);
    end
    span = (lim < 4000) ? lim + 2 : 4000;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ang = ref_ang + $urandom_range(0, 2 * span) - span;
      4: ang = ref_ang + $urandom_range(0, 2 * span) - span +
               (($urandom_range(0, 1) == 1) ? PI_BAU : -PI_BAU);
      5, 6: begin
        case ($urandom_range(0, 9))
          0:       ang = -HALF_PI_BAU - 1;
          1:       ang = -HALF_PI_BAU;
          2:       ang = -HALF_PI_BAU + 1;
          3:       ang = HALF_PI_BAU - 1;
          4:       ang = HALF_PI_BAU;
          5:       ang = HALF_PI_BAU + 1;
          6:       ang = -32768;
          7:       ang = 32767;
          8:       ang = -3 * HALF_PI_BAU;
          default: ang = 3 * HALF_PI_BAU + 1;
        endcase
      end
      default: ang = $urandom;
    endcase
    px.edge_angle = ANGLE_W'(ang);
    px.last_pixel = last;
    return px;
  endfunction

  // pixel sender: bursts of random length separated by random gaps
  always @(negedge clk) begin : pixel_driver
    pixel_t px;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (idle_left > 0) begin
        in_valid <= 1'b0;
        idle_left--;
      end else if (pixel_q.size() != 0) begin
        px = pixel_q.pop_front();
        in_template_weight <= px.template_weight;
        in_edge_strength   <= px.edge_strength;
        in_brightness      <= px.brightness;
        in_edge_angle      <= px.edge_angle;
        in_last_pixel      <= px.last_pixel;
        in_valid           <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 64);
          idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // score receiver stall pattern, mode drawn anew every segment
  always @(negedge clk) begin : score_stall_gen
    if (stall_tick == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 4));
      stall_tick = $urandom_range(20, 120);
    end else begin
      stall_tick--;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
      STALL_TOGGLE: out_stall <= stall_tick[1];
      default:      out_stall <= (stall_tick > 10);
    endcase
  end

  // monitor: config and pixel transfers feed the predictor, score transfers are checked
  always @(posedge clk) begin : score_monitor
    logic signed [SCORE_W-1:0] want;
    if (!rst_n) begin
      in_fire         <= 1'b0;
      ref_angle_cfg   = '0;
      angle_limit_cfg = '0;
      dark_limit_cfg  = DARK_LIMIT_RST;
      window_sum      = 0;
      quiet_cycles    = 0;
    end else begin
      in_fire <= in_valid && !in_stall;
      quiet_cycles++;
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        case (cfg_index)
          CFG_REF_ANGLE:   ref_angle_cfg   = cfg_data[REF_W-1:0];
          CFG_ANGLE_LIMIT: angle_limit_cfg = cfg_data[LIMIT_W-1:0];
          CFG_DARK_LIMIT:  dark_limit_cfg  = cfg_data[BRIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        quiet_cycles = 0;
        score_pixel('{template_weight: in_template_weight, edge_strength: in_edge_strength,
                      brightness: in_brightness, edge_angle: in_edge_angle,
                      last_pixel: in_last_pixel});
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (window_score_q.size() == 0) begin
          errors++;
          $display("%0t: score %0d with none expected", $time, out_score);
        end else begin
          want = window_score_q.pop_front();
          if (out_score !== want) begin
            errors++;
            $display("%0t: score mismatch, expected %0d actual %0d", $time, want, out_score);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("edge_angle_gated_template_score_core_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input int ref_ang, input int lim, input int dark);
    write_cfg(CFG_REF_ANGLE, ref_ang);
    write_cfg(CFG_ANGLE_LIMIT, lim);
    write_cfg(CFG_DARK_LIMIT, dark);
  endtask

  // wait until every pending pixel and expected score is through
  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_q.size() != 0 || in_valid || window_score_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int ref_ang;
    int lim;
    int dark;
    int len;
    int count;
    int k;
    int i;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset values: zero angle limit, nothing counts
    pixel_q.push_back(make_pixel(7, 255, 0, 0, 0));
    pixel_q.push_back(make_pixel(-8, 255, 0, 0, 1));
    pixel_q.push_back(make_pixel(7, 200, 10, 0, 1));
    wait_drained();

    // widest limits: weight and strength extremes, gating by zero fields
    apply_setting(0, 32767, 255);
    pixel_q.push_back(make_pixel(7, 255, 0, 0, 1));
    pixel_q.push_back(make_pixel(-8, 255, 254, -32768, 1));
    pixel_q.push_back(make_pixel(7, 255, 255, 0, 1));
    pixel_q.push_back(make_pixel(0, 255, 0, 0, 1));
    pixel_q.push_back(make_pixel(-1, 0, 0, 0, 1));
    pixel_q.push_back(make_pixel(3, 100, 0, 32767, 0));
    pixel_q.push_back(make_pixel(-2, 50, 0, -8192, 1));
    wait_drained();

    // top reference, exact match only: fold edges and the dark boundary
    apply_setting(HALF_PI_BAU, 1, 120);
    pixel_q.push_back(make_pixel(5, 10, 119, 8192, 0));
    pixel_q.push_back(make_pixel(5, 10, 119, -8192, 0));
    pixel_q.push_back(make_pixel(5, 10, 119, 8193, 0));
    pixel_q.push_back(make_pixel(5, 10, 119, 8191, 0));
    pixel_q.push_back(make_pixel(5, 10, 120, 8192, 0));
    pixel_q.push_back(make_pixel(5, 10, 0, 24576, 1));
    wait_drained();

    // bottom reference: single fold leaves angles past -pi out of range
    apply_setting(-HALF_PI_BAU, 2, 1);
    pixel_q.push_back(make_pixel(-3, 7, 0, -8191, 0));
    pixel_q.push_back(make_pixel(-3, 7, 0, -8190, 0));
    pixel_q.push_back(make_pixel(-3, 7, 0, -24576, 0));
    pixel_q.push_back(make_pixel(-3, 7, 0, -8192, 0));
    pixel_q.push_back(make_pixel(-3, 7, 1, -8191, 1));
    wait_drained();

    // score saturation at the lower bound, then a random tail inside the window
    apply_setting(0, 32767, 255);
    for (i = 0; i < 1060; i++) begin
      pixel_q.push_back(make_pixel(-8, 255, $urandom_range(0, 254), $urandom, 0));
    end
    for (i = 0; i < 12; i++) begin
      pixel_q.push_back(rand_pixel(0, 32767, 255, i == 11));
    end
    wait_drained();

    // random windows under a new setting per phase
    for (k = 0; k < RANDOM_PHASES; k++) begin
      ref_ang = $urandom_range(0, 2 * HALF_PI_BAU) - HALF_PI_BAU;
      if (k == 4) begin
        ref_ang = -HALF_PI_BAU;
      end else if (k == 5) begin
        ref_ang = HALF_PI_BAU;
      end
      case ($urandom_range(0, 2))
        0:       lim = $urandom_range(1, 16);
        1:       lim = $urandom_range(17, 4096);
        default: lim = $urandom_range(4097, 32767);
      endcase
      if (k == 1) begin
        lim = 0;
      end else if (k == 2) begin
        lim = 32767;
      end
      dark = $urandom_range(1, 255);
      if (k == 0) begin
        dark = 0;
      end else if (k == 3) begin
        dark = 255;
      end
      apply_setting(ref_ang, lim, dark);
      count = 0;
      while (count < PHASE_PIXELS) begin
        case ($urandom_range(0, 49))
          0:       len = $urandom_range(121, 400);
          1, 2, 3: len = $urandom_range(25, 120);
          default: len = $urandom_range(1, 24);
        endcase
        for (i = 0; i < len; i++) begin
          pixel_q.push_back(rand_pixel(ref_ang, lim, dark, i == len - 1));
        end
        count += len;
      end
      wait_drained();
    end

    if (errors == 0 && window_score_q.size() == 0) begin
      $display("edge_angle_gated_template_score_core_tb: PASS");
    end else begin
      $display("edge_angle_gated_template_score_core_tb: FAIL");
    end
    $finish;
  end

endmodule
